// ===== rtl/tsb_pkg.sv =====
// Shared types and constants for the text scrollback line buffer.
package tsb_pkg;

    localparam int ROWS_DEF = 64;
    localparam int COLS_DEF = 128;

    // Wide enough for a line length of up to 256 characters.
    localparam int LEN_W = 9;

    localparam logic [7:0] NEWLINE_CH = 8'd10;
    localparam logic [7:0] NULL_CH    = 8'd0;

    localparam logic FUNC_PUT  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    typedef struct packed {
        logic       func;
        logic [7:0] ch;
        logic [5:0] row;
        logic [6:0] col;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_char;
        logic [7:0] line_length;
        logic [6:0] line_count;
    } t_out_item;

    // Write and read strobes for the two stores.
    typedef struct packed {
        logic char_we;
        logic len_we;
        logic rd_en;
    } t_mem_ctl;

    // What the output stage needs to finish an item once the stores answer.
    typedef struct packed {
        logic             is_put;
        logic             row_ok;
        logic             bypass;
        logic             col_ok;
        logic [6:0]       col;
        logic [LEN_W-1:0] len;
        logic [6:0]       count;
    } t_info;

endpackage

// ===== rtl/text_scrollback_line_buffer_core.sv =====
// Top level of the text scrollback line buffer: handshakes, store read stage and result register.
//
// A scrollback ring of ROWS lines of up to COLS characters each.
// Input channel (i_in_valid, o_in_stall, i_in_item): a put item (func 0)
// appends ch to the newest line, where a newline opens a new empty line,
// a full line spills into a new one, byte 0 does nothing, and a full ring
// overwrites its oldest line. A read item (func 1) asks for the cell at
// row and col, with row 0 the oldest line held.
// Output channel (o_out_valid, i_out_stall, o_out_item): exactly one
// result item per input item, in order: the cell (0 outside the line),
// the line length and the number of lines held after the item.
// From acceptance, an item passes through the synchronous read of the
// character and length stores, then the result register. Throughput is
// one item per cycle while the receiver does not stall; puts and reads of
// any mix follow each other back to back, since a store write lands at
// the same edge that a following read is issued after.
// The newest line's length lives in a register and is forwarded to reads.
// While the receiver stalls, the result holds and one more item may wait
// in the read stage; after that o_in_stall rises.
// Reset empties the ring (no lines held) and clears all valid flags; the
// stores need no clearing, since only written cells are ever read.
module text_scrollback_line_buffer_core
    import tsb_pkg::*;
#(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int SW = $clog2(ROWS);
    localparam int AW = $clog2(ROWS * COLS);
    localparam int LW = $clog2(COLS + 1);

    t_mem_ctl      mem_ctl;
    logic [AW-1:0] char_waddr;
    logic [7:0]    char_wdata;
    logic [AW-1:0] char_raddr;
    logic [SW-1:0] len_waddr;
    logic [LW-1:0] len_wdata;
    logic [SW-1:0] len_raddr;
    logic [7:0]    char_rdata;
    logic [LW-1:0] len_rdata;
    t_info         info;

    // Read stage: holds the item whose store read is in flight or done.
    logic      r_s1_v;
    t_info     r_s1;
    logic      r_out_v;
    t_out_item r_out, n_out;
    logic      advance;
    logic      accept;
    logic [LEN_W-1:0] rd_len;

    // The read stage moves on whenever the result register is free or is
    // being emptied in this cycle.
    assign advance    = r_s1_v && (!r_out_v || !i_out_stall);
    assign o_in_stall = r_s1_v && !advance;
    assign accept     = i_in_valid && !o_in_stall;

    tsb_ctrl #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_acc        (accept),
        .i_item       (i_in_item),
        .o_ctl        (mem_ctl),
        .o_char_waddr (char_waddr),
        .o_char_wdata (char_wdata),
        .o_char_raddr (char_raddr),
        .o_len_waddr  (len_waddr),
        .o_len_wdata  (len_wdata),
        .o_len_raddr  (len_raddr),
        .o_info       (info)
    );

    // Read data registers only load on a read, so they hold while the
    // read stage waits behind a stalled result.
    tsb_store #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_store (
        .i_clk        (i_clk),
        .i_ctl        (mem_ctl),
        .i_char_waddr (char_waddr),
        .i_char_wdata (char_wdata),
        .i_char_raddr (char_raddr),
        .i_len_waddr  (len_waddr),
        .i_len_wdata  (len_wdata),
        .i_len_raddr  (len_raddr),
        .o_char_rdata (char_rdata),
        .o_len_rdata  (len_rdata)
    );

    // Finish the item: the newest line's length comes from the forwarded
    // register value, older lines from the length store.
    always_comb begin
        rd_len           = r_s1.bypass ? r_s1.len : LEN_W'(len_rdata);
        n_out.line_count = r_s1.count;
        n_out.read_char  = '0;
        n_out.line_length = '0;
        if (r_s1.is_put) begin
            n_out.line_length = 8'(r_s1.len);
        end else if (r_s1.row_ok) begin
            n_out.line_length = 8'(rd_len);
            if (r_s1.col_ok && (LEN_W'(r_s1.col) < rd_len)) begin
                n_out.read_char = char_rdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_v <= 1'b1;
            end else if (advance) begin
                r_s1_v <= 1'b0;
            end
            if (advance) begin
                r_out_v <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= info;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_item  = r_out;

endmodule

// ===== rtl/tsb_store.sv =====
// Character store and line length store, each with one write and one registered read.
module tsb_store
    import tsb_pkg::*;
#(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF,
    localparam int SW = $clog2(ROWS),
    localparam int AW = $clog2(ROWS * COLS),
    localparam int LW = $clog2(COLS + 1)
) (
    input  logic          i_clk,
    input  t_mem_ctl      i_ctl,
    input  logic [AW-1:0] i_char_waddr,
    input  logic [7:0]    i_char_wdata,
    input  logic [AW-1:0] i_char_raddr,
    input  logic [SW-1:0] i_len_waddr,
    input  logic [LW-1:0] i_len_wdata,
    input  logic [SW-1:0] i_len_raddr,
    output logic [7:0]    o_char_rdata,
    output logic [LW-1:0] o_len_rdata
);

    logic [7:0]    r_char_mem [ROWS*COLS];
    logic [LW-1:0] r_len_mem  [ROWS];

    always_ff @(posedge i_clk) begin
        if (i_ctl.char_we) begin
            r_char_mem[i_char_waddr] <= i_char_wdata;
        end
        if (i_ctl.rd_en) begin
            o_char_rdata <= r_char_mem[i_char_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.len_we) begin
            r_len_mem[i_len_waddr] <= i_len_wdata;
        end
        if (i_ctl.rd_en) begin
            o_len_rdata <= r_len_mem[i_len_raddr];
        end
    end

endmodule

// ===== rtl/tsb_ctrl.sv =====
// Ring pointers, newest line length and store addressing for put and read items.
module tsb_ctrl
    import tsb_pkg::*;
#(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF,
    localparam int SW = $clog2(ROWS),
    localparam int HW = $clog2(ROWS + 1),
    localparam int AW = $clog2(ROWS * COLS),
    localparam int LW = $clog2(COLS + 1),
    localparam int SUMW = ((SW > 6) ? SW : 6) + 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_acc,
    input  t_in_item      i_item,
    output t_mem_ctl      o_ctl,
    output logic [AW-1:0] o_char_waddr,
    output logic [7:0]    o_char_wdata,
    output logic [AW-1:0] o_char_raddr,
    output logic [SW-1:0] o_len_waddr,
    output logic [LW-1:0] o_len_wdata,
    output logic [SW-1:0] o_len_raddr,
    output t_info         o_info
);

    logic [HW-1:0] r_held,   n_held;
    logic [SW-1:0] r_oldest, n_oldest;
    logic [SW-1:0] r_newest, n_newest;
    logic [LW-1:0] r_nlen,   n_nlen;

    logic            put_go;
    logic [SUMW-1:0] slot_sum;
    logic [SW-1:0]   rd_slot;
    logic            row_ok;
    logic            bypass;

    // Put path. The newest line keeps its length in r_nlen; the length store
    // is written only when a line stops being the newest one.
    always_comb begin
        n_held       = r_held;
        n_oldest     = r_oldest;
        n_newest     = r_newest;
        n_nlen       = r_nlen;
        o_ctl        = '0;
        o_ctl.rd_en  = i_acc && (i_item.func == FUNC_READ);
        o_len_waddr  = r_newest;
        o_len_wdata  = r_nlen;
        o_char_waddr = '0;
        o_char_wdata = i_item.ch;

        put_go = i_acc && (i_item.func == FUNC_PUT) && (i_item.ch != NULL_CH);

        if (put_go) begin
            if (r_held == '0) begin
                n_held   = HW'(1);
                n_newest = r_oldest;
                n_nlen   = '0;
            end
            if ((i_item.ch == NEWLINE_CH) || (n_nlen == LW'(COLS))) begin
                o_ctl.len_we = 1'b1;
                o_len_waddr  = n_newest;
                o_len_wdata  = n_nlen;
                if (n_held < HW'(ROWS)) begin
                    n_newest = (n_newest == SW'(ROWS - 1)) ? '0 : n_newest + SW'(1);
                    n_held   = n_held + HW'(1);
                end else begin
                    n_newest = n_oldest;
                    n_oldest = (n_oldest == SW'(ROWS - 1)) ? '0 : n_oldest + SW'(1);
                end
                n_nlen = '0;
            end
            if (i_item.ch != NEWLINE_CH) begin
                o_ctl.char_we = 1'b1;
                o_char_waddr  = AW'(32'(n_newest) * COLS + 32'(n_nlen));
                n_nlen        = n_nlen + LW'(1);
            end
        end
    end

    // Read path: logical row to slot, with one wrap correction.
    always_comb begin
        slot_sum     = SUMW'(r_oldest) + SUMW'(i_item.row);
        rd_slot      = (slot_sum >= SUMW'(ROWS)) ? SW'(slot_sum - SUMW'(ROWS)) : SW'(slot_sum);
        row_ok       = 32'(i_item.row) < 32'(r_held);
        bypass       = (32'(i_item.row) + 32'd1) == 32'(r_held);
        o_len_raddr  = rd_slot;
        o_char_raddr = AW'(32'(rd_slot) * COLS + 32'(i_item.col));
    end

    always_comb begin
        o_info.is_put = (i_item.func == FUNC_PUT);
        o_info.row_ok = row_ok;
        o_info.bypass = bypass;
        o_info.col_ok = 32'(i_item.col) < COLS;
        o_info.col    = i_item.col;
        if (i_item.func == FUNC_PUT) begin
            o_info.len   = LEN_W'(n_nlen);
            o_info.count = 7'(n_held);
        end else begin
            o_info.len   = LEN_W'(r_nlen);
            o_info.count = 7'(r_held);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held   <= '0;
            r_oldest <= '0;
            r_newest <= '0;
            r_nlen   <= '0;
        end else if (i_acc) begin
            r_held   <= n_held;
            r_oldest <= n_oldest;
            r_newest <= n_newest;
            r_nlen   <= n_nlen;
        end
    end

endmodule

// ===== rtl/tsb_checker.sv =====
// Port-level checks for the text scrollback line buffer, bound to its top level.
module tsb_checker
    import tsb_pkg::*;
#(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed");

    // The input side only backs up when a result is waiting.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result pending");

    // Line count and length stay within the ring's geometry.
    a_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((32'(o_out_item.line_count) <= ROWS || ROWS > 127)
                      && (32'(o_out_item.line_length) <= COLS || COLS > 255)))
        else $error("line count or length out of range");

    // The number of lines held never falls from one result to the next.
    a_count_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall) ##1 o_out_valid
        |-> (o_out_item.line_count >= $past(o_out_item.line_count) || ROWS > 127))
        else $error("line count decreased");

endmodule

bind text_scrollback_line_buffer_core tsb_checker #(
    .ROWS (ROWS),
    .COLS (COLS)
) u_tsb_checker (.*);
